FILE: rtl/rfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_pkg: shared types and constants for the rotation frame stack
// CORDIC arctangent table, status codes, sequencer states.
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_FRAC  = 30;
  localparam int CW           = 34;
  localparam logic [CW-1:0] CORDIC_GAIN_INV = 34'h026DD3B6A;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_LOAD_WAIT,
    S_CORDIC,
    S_TRIG,
    S_MIX_A,
    S_MIX_B,
    S_STORE,
    S_READ,
    S_READ_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } cordic_ctl_t;

  function automatic logic [CW-1:0] atan_lut(input logic [4:0] i);
    logic [CW-1:0] r;
    case (i)
      5'd0:  r = 34'h020000000;
      5'd1:  r = 34'h012E4051E;
      5'd2:  r = 34'h009FB385B;
      5'd3:  r = 34'h0051111D4;
      5'd4:  r = 34'h0028B0D43;
      5'd5:  r = 34'h00145D7E1;
      5'd6:  r = 34'h000A2F61E;
      5'd7:  r = 34'h000517C55;
      5'd8:  r = 34'h00028BE53;
      5'd9:  r = 34'h000145F2F;
      5'd10: r = 34'h0000A2F98;
      5'd11: r = 34'h0000517CC;
      5'd12: r = 34'h000028BE6;
      5'd13: r = 34'h0000145F3;
      5'd14: r = 34'h00000A2FA;
      5'd15: r = 34'h00000517D;
      5'd16: r = 34'h0000028BE;
      5'd17: r = 34'h00000145F;
      5'd18: r = 34'h000000A30;
      5'd19: r = 34'h000000518;
      5'd20: r = 34'h00000028C;
      5'd21: r = 34'h000000146;
      5'd22: r = 34'h0000000A3;
      5'd23: r = 34'h000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/rfs_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_cordic: iterative sine and cosine
// One add/shift stage reused for 24 steps, then quadrant fold, round, clamp.
// ----------------------------------------------------------------------------
module rfs_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_BITS  = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic                        done,
  output logic signed [COEF_BITS-1:0] cos_q,
  output logic signed [COEF_BITS-1:0] sin_q
);
  import rfs_pkg::*;

  localparam int FRAC = COEF_BITS - 2;
  localparam int SH   = CORDIC_FRAC - FRAC;

  logic signed [CW-1:0] x, y, z;
  logic [4:0] step;
  logic       run;
  logic [1:0] quad;
  logic [31:0] u;
  logic signed [CW-1:0] dx, dy, c, s;
  logic signed [CW:0] cr, sr;
  logic signed [CW:0] one;

  assign u = 32'(angle) << (32 - ANGLE_BITS);
  assign dx = x >>> step;
  assign dy = y >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        if (step == 5'(CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN_INV;
      y    <= '0;
      z    <= CW'({2'b00, u[29:0]});
      quad <= u[31:30];
    end else if (run) begin
      if (!z[CW-1]) begin
        x <= x - dy;
        y <= y + dx;
        z <= z - atan_lut(step);
      end else begin
        x <= x + dy;
        y <= y - dx;
        z <= z + atan_lut(step);
      end
    end
  end

  always_comb begin
    case (quad)
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    one = (CW+1)'(1) <<< FRAC;
    cr = ((CW+1)'(c) + ((CW+1)'(1) <<< (SH - 1))) >>> SH;
    sr = ((CW+1)'(s) + ((CW+1)'(1) <<< (SH - 1))) >>> SH;
    if (cr > one) cr = one;
    else if (cr < -one) cr = -one;
    if (sr > one) sr = one;
    else if (sr < -one) sr = -one;
  end

  assign cos_q = cr[COEF_BITS-1:0];
  assign sin_q = sr[COEF_BITS-1:0];
endmodule

FILE: rtl/rfs_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_mac: shared product unit
// Two registered products summed, rounded half up and saturated.
// ----------------------------------------------------------------------------
module rfs_mac #(
  parameter int COEF_BITS = 18
) (
  input  logic                        clk,
  input  logic signed [COEF_BITS-1:0] p,
  input  logic signed [COEF_BITS-1:0] a,
  input  logic signed [COEF_BITS-1:0] q,
  input  logic signed [COEF_BITS-1:0] b,
  output logic signed [COEF_BITS-1:0] r
);
  localparam int FRAC = COEF_BITS - 2;
  localparam int PW   = 2 * COEF_BITS + 1;

  logic signed [PW-1:0] pa, qb, sum, sh;
  logic signed [PW-1:0] hi, lo;

  always_ff @(posedge clk) begin
    pa <= PW'(p) * PW'(a);
    qb <= PW'(q) * PW'(b);
  end

  always_comb begin
    hi  = (PW'(1) <<< (COEF_BITS - 1)) - PW'(1);
    lo  = -hi - PW'(1);
    sum = pa + qb + (PW'(1) <<< (FRAC - 1));
    sh  = sum >>> FRAC;
    if (sh > hi) sh = hi;
    else if (sh < lo) sh = lo;
  end

  assign r = sh[COEF_BITS-1:0];
endmodule

FILE: rtl/rotation_frame_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_frame_stack_top: stack of 3x3 rotation frames
// Push (operation 0) rotates a copy of the top frame by angles about y, z, x
// and stacks it; pop (operation 1) drops the top frame. Each transaction
// returns the new top matrix, the level and a status.
// Input channel in_valid/in_stall, output channel out_valid/out_stall.
// A push loads the top frame from a single-port frame memory, makes three
// passes (a 24-step CORDIC run on one shared stage, a latch of sine and
// cosine, the row mixes on one two-product unit), does 9 frame writes and
// reads the frame back, then raises out_valid. A pop or a refused push goes
// straight to reading the frame back. The block takes one transaction at a
// time; in_stall stays high until the result is taken and drops in the
// cycle after. A stalled result holds until out_stall drops. Reset empties
// the stack to the global identity frame; memory contents need no clearing.
// ----------------------------------------------------------------------------
module rotation_frame_stack_top #(
  parameter int STACK_DEPTH = 16,
  parameter int ANGLE_BITS  = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] m11,
  output logic signed [17:0] m21,
  output logic signed [17:0] m31,
  output logic signed [17:0] m12,
  output logic signed [17:0] m22,
  output logic signed [17:0] m32,
  output logic signed [17:0] m13,
  output logic signed [17:0] m23,
  output logic signed [17:0] m33,
  output logic [4:0]         level,
  output logic [1:0]         status
);
  import rfs_pkg::*;

  localparam int FRAC = COEF_BITS - 2;
  localparam int LW   = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH * 9);
  localparam int MD   = STACK_DEPTH * 9;

  state_t state, state_next;

  logic signed [COEF_BITS-1:0] mat [9];
  logic signed [COEF_BITS-1:0] mem [MD];
  logic signed [COEF_BITS-1:0] rd;
  logic [AW-1:0]  addr;
  logic           we;
  logic [LW-1:0]  lvl;
  logic [1:0]     stat;
  logic [ANGLE_BITS-1:0] ax, ay, az;
  logic [1:0]     pass;
  logic [1:0]     cpass;
  logic [3:0]     idx;
  logic [1:0]     col;
  logic [1:0]     r1, r2;
  logic [3:0]     i1, i2;
  logic signed [COEF_BITS-1:0] cc, ss, ma, mb, mp, mq, mr, ps;
  logic           cdone;
  cordic_ctl_t    cctl;
  logic [ANGLE_BITS-1:0] cang;
  logic signed [COEF_BITS-1:0] ccos, csin;
  logic           accept;
  logic           pend;
  logic [3:0]     pend_i;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cpass = (state == S_MIX_B) ? pass + 2'd1 : pass;
    case (cpass)
      2'd0:    cang = ay;
      2'd1:    cang = az;
      default: cang = ax;
    endcase
    case (pass)
      2'd0:    begin r1 = 2'd0; r2 = 2'd2; end
      2'd1:    begin r1 = 2'd0; r2 = 2'd1; end
      default: begin r1 = 2'd1; r2 = 2'd2; end
    endcase
    i1 = 4'(r1) + 4'(col) * 4'd3;
    i2 = 4'(r2) + 4'(col) * 4'd3;
  end

  rfs_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cctl.start), .angle(cang),
    .done(cdone), .cos_q(ccos), .sin_q(csin)
  );

  always_comb begin
    ps = (pass == 2'd0) ? -ss : ss;
    if (state == S_MIX_A) begin
      mp = cc;  mq = ps;
    end else begin
      mp = -ps; mq = cc;
    end
    ma = mat[i1];
    mb = mat[i2];
  end

  rfs_mac #(.COEF_BITS(COEF_BITS)) u_mac (
    .clk(clk), .p(mp), .a(ma), .q(mq), .b(mb), .r(mr)
  );

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= mat[idx];
    rd <= mem[addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        if (operation == OP_PUSH && 32'(lvl) < STACK_DEPTH) state_next = S_LOAD;
        else state_next = S_READ;
      end
      S_LOAD:      state_next = S_LOAD_WAIT;
      S_LOAD_WAIT: if (idx == 4'd9) state_next = S_CORDIC;
      S_CORDIC:    if (cdone) state_next = S_TRIG;
      S_TRIG:      state_next = S_MIX_A;
      S_MIX_A:     state_next = S_MIX_B;
      S_MIX_B: begin
        if (col == 2'd2) state_next = (pass == 2'd2) ? S_STORE : S_CORDIC;
        else state_next = S_MIX_A;
      end
      S_STORE:     if (idx == 4'd8) state_next = S_READ;
      S_READ:      state_next = S_READ_WAIT;
      S_READ_WAIT: if (idx == 4'd9) state_next = S_OUT;
      S_OUT:       if (!out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cctl.start = 1'b0;
    cctl.busy  = (state == S_CORDIC);
    we = (state == S_STORE);
    addr = '0;
    case (state)
      S_LOAD, S_LOAD_WAIT:
        addr = AW'((32'(lvl) - 1) * 9 + 32'(idx));
      S_STORE:
        addr = AW'(32'(lvl) * 9 + 32'(idx));
      S_READ, S_READ_WAIT:
        addr = AW'((32'(lvl) - 1) * 9 + 32'(idx));
      default: addr = '0;
    endcase
    if (state == S_LOAD_WAIT && idx == 4'd9) cctl.start = 1'b1;
    if (state == S_MIX_B && col == 2'd2 && pass != 2'd2) cctl.start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= (state_next == S_OUT);
      if (state == S_IDLE && accept) begin
        if (operation == OP_POP && lvl != '0) lvl <= lvl - LW'(1);
      end
      if (state == S_STORE && idx == 4'd8) lvl <= lvl + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx <= '0;
        pass <= '0;
        col <= '0;
        if (accept) begin
          ax <= ANGLE_BITS'(angle_x);
          ay <= ANGLE_BITS'(angle_y);
          az <= ANGLE_BITS'(angle_z);
          if (operation == OP_PUSH)
            stat <= (32'(lvl) < STACK_DEPTH) ? ST_OK : ST_FULL;
          else
            stat <= (lvl == '0) ? ST_UNDERFLOW : ST_OK;
          if (lvl == '0) begin
            for (int k = 0; k < 9; k++)
              mat[k] <= (k % 4 == 0) ? COEF_BITS'(1) <<< FRAC : '0;
          end
        end
      end
      S_LOAD: idx <= idx + 4'd1;
      S_LOAD_WAIT: begin
        if (lvl != '0) mat[idx - 4'd1] <= rd;
        if (idx == 4'd9) idx <= '0;
        else idx <= idx + 4'd1;
      end
      S_TRIG: begin
        cc <= ccos;
        ss <= csin;
        col <= '0;
      end
      S_MIX_B: mat[i1] <= mr;
      S_STORE: if (idx == 4'd8) idx <= '0; else idx <= idx + 4'd1;
      S_READ: idx <= idx + 4'd1;
      S_READ_WAIT: begin
        if (lvl != '0) mat[idx - 4'd1] <= rd;
        else begin
          for (int k = 0; k < 9; k++)
            mat[k] <= (k % 4 == 0) ? COEF_BITS'(1) <<< FRAC : '0;
        end
        if (idx != 4'd9) idx <= idx + 4'd1;
      end
      default: ;
    endcase
    if (state == S_MIX_A && col != 2'd0) mat[i2 - 4'd3] <= mr;
    if (pend) mat[pend_i] <= mr;
    if (state == S_MIX_B) begin
      if (col == 2'd2) begin
        col <= '0;
        pass <= pass + 2'd1;
      end else col <= col + 2'd1;
    end
    if (state == S_MIX_A && col == 2'd0 && pass != 2'd0 && cctl.busy) ;
  end

  // second-row result of the last column is written in the cycle after S_MIX_B
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else pend <= (state == S_MIX_B && col == 2'd2);
    pend_i <= i2;
  end

  assign m11 = 18'(mat[0]);
  assign m21 = 18'(mat[1]);
  assign m31 = 18'(mat[2]);
  assign m12 = 18'(mat[3]);
  assign m22 = 18'(mat[4]);
  assign m32 = 18'(mat[5]);
  assign m13 = 18'(mat[6]);
  assign m23 = 18'(mat[7]);
  assign m33 = 18'(mat[8]);
  assign level  = 5'(lvl);
  assign status = stat;
endmodule

FILE: rtl/rfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_checker: port-level checks for the rotation frame stack
// Handshake and level/status consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module rfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] level,
  input logic [1:0] status
);
  import rfs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) && $stable(status))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_under: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNDERFLOW |-> level == 5'd0)
    else $error("underflow reported above global level");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");
endmodule

bind rotation_frame_stack_top rfs_checker u_rfs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .level(level), .status(status)
);

FILE: dv/rotation_frame_stack_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_frame_stack_top_tb: self-checking bench for the rotation frame stack
// A directed table covers the global frame, the angle extremes, a full stack
// and pops down to the global frame. Random push/pop traffic follows. Every
// transaction is predicted by the table or a local CORDIC and matrix model,
// and results are compared field by field under random gaps and output stalls.
// ----------------------------------------------------------------------------
module rotation_frame_stack_top_tb;
  import rfs_pkg::*;

  localparam int DEPTH = 16;
  localparam int ONE = 65536;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [8:0][17:0] m;
    logic [4:0] lvl;
    logic [1:0] st;
  } frame_result_t;

  typedef struct {
    logic op;
    logic [15:0] ax, ay, az;
    bit typed;
    logic [4:0] lvl;
    logic [1:0] st;
  } stim_row_t;

  logic clk, rst, in_valid, in_stall, operation, out_valid, out_stall;
  logic [15:0] angle_x, angle_y, angle_z;
  logic signed [17:0] m11, m21, m31, m12, m22, m32, m13, m23, m33;
  logic [4:0] level;
  logic [1:0] status;

  rotation_frame_stack_top u_dut (.*);

  const longint atan_steps[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  longint frames [DEPTH][9];
  int depth_now;
  frame_result_t pending_q[$];
  int errors;
  longint cycles;

  function automatic longint to_coef(longint v);
    longint r;
    r = (v + (64'sd1 <<< 13)) >>> 14;
    return r < -ONE ? -ONE : (r > ONE ? ONE : r);
  endfunction

  function automatic void trig(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy, tc, ts;
    logic [31:0] u;
    u = {ang, 16'h0};
    z = longint'(u[29:0]);
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end else begin
        x += dx; y -= dy; z += atan_steps[i];
      end
    end
    case (u[31:30])
      2'd0: begin tc = x; ts = y; end
      2'd1: begin tc = -y; ts = x; end
      2'd2: begin tc = -x; ts = -y; end
      default: begin tc = y; ts = -x; end
    endcase
    c = to_coef(tc);
    s = to_coef(ts);
  endfunction

  function automatic longint mix(longint p, longint a, longint q, longint b);
    longint r;
    r = (p * a + q * b + 64'sd32768) >>> 16;
    return r < -131072 ? -131072 : (r > 131071 ? 131071 : r);
  endfunction

  function automatic void turn_rows(ref longint m[9], input longint c, input longint s,
                                    input int r1, input int r2);
    longint a, b;
    for (int j = 0; j < 3; j++) begin
      a = m[r1 + 3 * j];
      b = m[r2 + 3 * j];
      m[r1 + 3 * j] = mix(c, a, s, b);
      m[r2 + 3 * j] = mix(-s, a, c, b);
    end
  endfunction

  function automatic frame_result_t apply_frame_op(logic op, logic [15:0] ax,
                                                    logic [15:0] ay, logic [15:0] az);
    frame_result_t r;
    longint m[9];
    longint c, s;
    r.st = ST_OK;
    if (op == OP_PUSH) begin
      if (depth_now >= DEPTH) r.st = ST_FULL;
      else begin
        for (int k = 0; k < 9; k++)
          m[k] = depth_now == 0 ? ((k % 4 == 0) ? ONE : 0) : frames[depth_now - 1][k];
        trig(ay, c, s); turn_rows(m, c, -s, 0, 2);
        trig(az, c, s); turn_rows(m, c, s, 0, 1);
        trig(ax, c, s); turn_rows(m, c, s, 1, 2);
        frames[depth_now] = m;
        depth_now++;
      end
    end else begin
      if (depth_now == 0) r.st = ST_UNDERFLOW;
      else depth_now--;
    end
    for (int k = 0; k < 9; k++)
      r.m[k] = depth_now == 0 ? ((k % 4 == 0) ? 18'(ONE) : 18'd0)
                              : frames[depth_now - 1][k][17:0];
    r.lvl = 5'(depth_now);
    return r;
  endfunction

  task automatic send(stim_row_t row);
    frame_result_t r;
    int gap;
    operation <= row.op;
    angle_x <= row.ax;
    angle_y <= row.ay;
    angle_z <= row.az;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    r = apply_frame_op(row.op, row.ax, row.ay, row.az);
    if (row.typed) begin
      for (int k = 0; k < 9; k++) r.m[k] = (k % 4 == 0) ? 18'(ONE) : 18'd0;
      r.lvl = row.lvl;
      r.st = row.st;
    end
    pending_q.push_back(r);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(($urandom_range(0, 7)) << 13);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_frame_stack_top verification failed");
      $finish;
    end
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      case ($urandom_range(0, 9))
        0: hold = $urandom_range(20, 80);
        1, 2, 3: hold = 0;
        default: hold = $urandom_range(1, 3);
      endcase
      out_stall <= hold > 0;
      repeat (hold > 0 ? hold : $urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    frame_result_t e;
    logic [8:0][17:0] got;
    if (!rst && out_valid && !out_stall) begin
      got = {m33, m23, m13, m32, m22, m12, m31, m21, m11};
      if (pending_q.size() == 0) begin
        $display("%0t: result with no transaction pending", $time);
        errors++;
      end else begin
        e = pending_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== e.m[k]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, k % 3 + 1, k / 3 + 1,
                     $signed(e.m[k]), $signed(got[k]));
            errors++;
          end
        if (level !== e.lvl) begin
          $display("%0t: level expected %0d actual %0d", $time, e.lvl, level);
          errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int waited;
    errors = 0;
    cycles = 0;
    depth_now = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_PUSH;
    angle_x = '0;
    angle_y = '0;
    angle_z = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{OP_POP, 16'h0, 16'h0, 16'h0, 1, 5'd0, ST_UNDERFLOW});
    rows.push_back('{OP_PUSH, 16'h0, 16'h0, 16'h0, 1, 5'd1, ST_OK});
    rows.push_back('{OP_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 5'd0, ST_OK});
    rows.push_back('{OP_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h4000, 16'h0, 16'h0, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h0, 16'h4000, 16'h0, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h0, 16'h0, 16'h4000, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'hC000, 16'hC000, 16'hC000, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h2000, 16'h6000, 16'hA000, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'hE000, 16'h3FFF, 16'h4001, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h7FFF, 16'h8001, 16'hBFFF, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h0001, 16'h5555, 16'hAAAA, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h1234, 16'hFEDC, 16'h0F0F, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'hF0F0, 16'h0FF0, 16'h3C3C, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h9999, 16'h6666, 16'hCCCC, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h0100, 16'h8080, 16'hFF00, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'hA5A5, 16'h5A5A, 16'h0002, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h3333, 16'hDDDD, 16'h7777, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h1111, 16'h2222, 16'h4444, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h8888, 16'hBBBB, 16'hEEEE, 0, 0, 0});
    rows.push_back('{OP_PUSH, 16'h0, 16'h0, 16'h0, 0, 0, 0});
    rows.push_back('{OP_POP, 16'h0, 16'h0, 16'h0, 0, 0, 0});
    foreach (rows[i]) send(rows[i]);

    for (int n = 0; n < 1500; n++) begin
      row.typed = 0;
      row.lvl = '0;
      row.st = '0;
      row.ax = pick_angle();
      row.ay = pick_angle();
      row.az = pick_angle();
      if (n % 300 < 40) row.op = OP_PUSH;
      else if (n % 300 < 80) row.op = OP_POP;
      else row.op = $urandom_range(0, 99) < 55 ? OP_PUSH : OP_POP;
      send(row);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0)
      $display("rotation_frame_stack_top verification clean");
    else
      $display("rotation_frame_stack_top verification failed");
    $finish;
  end

endmodule
